// File: rtl/reduced_fraction_arithmetic_top_assert.svh
// assertion macros for the reduced fraction arithmetic block
// used by reduced_fraction_arithmetic_top, no other dependencies
`ifndef REDUCED_FRACTION_ARITHMETIC_TOP_ASSERT_SVH
`define REDUCED_FRACTION_ARITHMETIC_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RFA_ASSERT_NOW(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RFA_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rfa_pkg.sv
// shared types, constants and helpers for the reduced fraction arithmetic block
// used by rfa_div and reduced_fraction_arithmetic_top
package rfa_pkg;

    localparam int FIELD_BITS   = 16;
    localparam int OPERAND_BITS = 16;
    localparam int RES_BITS     = 32;
    localparam int DIV_CNT_BITS = $clog2(RES_BITS);
    localparam int NUM_PROD     = 5;
    localparam int NUM_RES      = 8;
    localparam int PROD_IDX_BITS = $clog2(NUM_PROD);
    localparam int RES_IDX_BITS  = $clog2(NUM_RES);

    typedef logic signed [OPERAND_BITS-1:0] opnd_t;
    typedef logic signed [RES_BITS-1:0]     res_t;
    typedef logic [PROD_IDX_BITS-1:0]       prod_idx_t;
    typedef logic [1:0]                     pair_t;

    // partial products, in the order the multiplier produces them
    localparam prod_idx_t PROD_NA_DB = prod_idx_t'(0);
    localparam prod_idx_t PROD_NB_DA = prod_idx_t'(1);
    localparam prod_idx_t PROD_DA_DB = prod_idx_t'(2);
    localparam prod_idx_t PROD_NA_NB = prod_idx_t'(3);
    localparam prod_idx_t PROD_DA_NB = prod_idx_t'(4);

    // result pairs, in reduction order
    localparam pair_t PAIR_SUM  = 2'd0;
    localparam pair_t PAIR_DIFF = 2'd1;
    localparam pair_t PAIR_PROD = 2'd2;
    localparam pair_t PAIR_QUOT = 2'd3;

    typedef struct packed {
        logic start;
        res_t dividend;
        res_t divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        res_t quot;
        res_t rem;
    } div_rsp_t;

    // low operand bits, read as signed, most negative value pulled in by one
    function automatic opnd_t take_operand(logic [FIELD_BITS-1:0] raw);
        opnd_t v;
        v = opnd_t'(raw[OPERAND_BITS-1:0]);
        if (v == {1'b1, {(OPERAND_BITS-1){1'b0}}})
            v = {1'b1, {(OPERAND_BITS-2){1'b0}}, 1'b1};
        return v;
    endfunction

endpackage

// File: rtl/rfa_div.sv
// shared iterative signed divider, truncating quotient and remainder as in C
// one quotient bit per cycle; depends on rfa_pkg
module rfa_div (
    input  logic             clk,
    input  logic             rst_n,
    input  rfa_pkg::div_req_t req,
    output rfa_pkg::div_rsp_t rsp
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIX
    } div_state_t;

    div_state_t                        state_reg;
    logic [rfa_pkg::DIV_CNT_BITS-1:0]  cnt_reg;
    logic [rfa_pkg::RES_BITS-1:0]      rem_reg;
    logic [rfa_pkg::RES_BITS-1:0]      quo_reg;
    logic [rfa_pkg::RES_BITS-1:0]      dvs_reg;
    logic                              neg_q_reg;
    logic                              neg_r_reg;
    rfa_pkg::div_rsp_t                 rsp_reg;

    logic [rfa_pkg::RES_BITS-1:0]      rem_shift;
    logic [rfa_pkg::RES_BITS-1:0]      rem_sub;
    logic                              fits;

    // remainder stays below the divisor magnitude, so its top bit is always clear
    assign rem_shift = {rem_reg[rfa_pkg::RES_BITS-2:0], quo_reg[rfa_pkg::RES_BITS-1]};
    assign fits      = rem_shift >= dvs_reg;
    assign rem_sub   = rem_shift - dvs_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            dvs_reg   <= '0;
            neg_q_reg <= 1'b0;
            neg_r_reg <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            rsp_reg.done <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        neg_r_reg <= req.dividend[rfa_pkg::RES_BITS-1];
                        neg_q_reg <= req.dividend[rfa_pkg::RES_BITS-1]
                                     ^ req.divisor[rfa_pkg::RES_BITS-1];
                        quo_reg   <= req.dividend[rfa_pkg::RES_BITS-1]
                                     ? (~req.dividend + 1'b1) : req.dividend;
                        dvs_reg   <= req.divisor[rfa_pkg::RES_BITS-1]
                                     ? (~req.divisor + 1'b1) : req.divisor;
                        rem_reg   <= '0;
                        cnt_reg   <= '1;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= fits ? rem_sub : rem_shift;
                    quo_reg <= {quo_reg[rfa_pkg::RES_BITS-2:0], fits};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= D_FIX;
                end
                D_FIX:
                begin
                    rsp_reg.quot <= neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
                    rsp_reg.rem  <= neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;
                    rsp_reg.done <= 1'b1;
                    state_reg    <= D_IDLE;
                end
                default:
                    state_reg <= D_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/reduced_fraction_arithmetic_top.sv
// reduced fraction arithmetic: sum, difference, product, quotient of two fractions
// sequencer, shared multiplier and gcd loop; depends on rfa_pkg, rfa_div and
// reduced_fraction_arithmetic_top_assert.svh
//
// usage: drive num_a, den_a, num_b, den_b and raise start while busy is low;
// that edge is the input transfer. busy stays high until the result is ready.
// one cycle of done marks the result transfer on the result ports; the receiver
// cannot stall, so the result must be taken in that cycle.
// an item first forms its partial products on the shared multiplier, then runs
// divisions on the shared radix-2 divider (32 quotient bits, one per cycle,
// plus request, sign fix and hand-back). each of up to four pairs needs one
// division per euclid step (up to about 46) plus two to reduce, so the
// divider sets the time an item takes.
// a zero denominator skips the work: done follows in the cycle after the transfer.
// a new item may be started in the cycle done is high.
// reset clears the sequencer and results; the block is idle after reset.
`include "reduced_fraction_arithmetic_top_assert.svh"

module reduced_fraction_arithmetic_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [rfa_pkg::FIELD_BITS-1:0]  num_a,
    input  logic signed [rfa_pkg::FIELD_BITS-1:0]  den_a,
    input  logic signed [rfa_pkg::FIELD_BITS-1:0]  num_b,
    input  logic signed [rfa_pkg::FIELD_BITS-1:0]  den_b,
    output logic                                   done,
    output logic signed [rfa_pkg::RES_BITS-1:0]    sum_num,
    output logic signed [rfa_pkg::RES_BITS-1:0]    sum_den,
    output logic signed [rfa_pkg::RES_BITS-1:0]    diff_num,
    output logic signed [rfa_pkg::RES_BITS-1:0]    diff_den,
    output logic signed [rfa_pkg::RES_BITS-1:0]    prod_num,
    output logic signed [rfa_pkg::RES_BITS-1:0]    prod_den,
    output logic signed [rfa_pkg::RES_BITS-1:0]    quot_num,
    output logic signed [rfa_pkg::RES_BITS-1:0]    quot_den,
    output logic                                   zero_den_error,
    output logic                                   quot_invalid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_GCD,
        S_GCD_WAIT,
        S_DIVN_WAIT,
        S_DIVD_WAIT
    } state_t;

    state_t                 state_reg;
    logic                   done_reg;
    logic                   zero_den_reg;
    logic                   quot_inv_reg;
    rfa_pkg::opnd_t         na_reg;
    rfa_pkg::opnd_t         da_reg;
    rfa_pkg::opnd_t         nb_reg;
    rfa_pkg::opnd_t         db_reg;
    rfa_pkg::prod_idx_t     mul_idx_reg;
    rfa_pkg::pair_t         pair_reg;
    rfa_pkg::res_t          prod_reg [rfa_pkg::NUM_PROD];
    rfa_pkg::res_t          res_reg [rfa_pkg::NUM_RES];
    rfa_pkg::res_t          n_reg;
    rfa_pkg::res_t          d_reg;
    rfa_pkg::res_t          x_reg;
    rfa_pkg::res_t          y_reg;
    rfa_pkg::res_t          qn_reg;
    rfa_pkg::div_req_t      div_req_reg;
    rfa_pkg::div_rsp_t      div_rsp;

    rfa_pkg::opnd_t         na_in;
    rfa_pkg::opnd_t         da_in;
    rfa_pkg::opnd_t         nb_in;
    rfa_pkg::opnd_t         db_in;
    logic                   zero_den_in;
    rfa_pkg::opnd_t         mul_a;
    rfa_pkg::opnd_t         mul_b;
    logic signed [2*rfa_pkg::OPERAND_BITS-1:0] mul_p;
    rfa_pkg::res_t          pair_n;
    rfa_pkg::res_t          pair_d;
    logic                   last_pair;
    logic [rfa_pkg::RES_IDX_BITS-1:0] res_idx;

    rfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        na_in       = rfa_pkg::take_operand(num_a);
        da_in       = rfa_pkg::take_operand(den_a);
        nb_in       = rfa_pkg::take_operand(num_b);
        db_in       = rfa_pkg::take_operand(den_b);
        zero_den_in = (da_in == '0) || (db_in == '0);
    end

    // one shared multiplier, one partial product per cycle
    always_comb
    begin
        case (mul_idx_reg)
            rfa_pkg::PROD_NA_DB: begin mul_a = na_reg; mul_b = db_reg; end
            rfa_pkg::PROD_NB_DA: begin mul_a = nb_reg; mul_b = da_reg; end
            rfa_pkg::PROD_DA_DB: begin mul_a = da_reg; mul_b = db_reg; end
            rfa_pkg::PROD_NA_NB: begin mul_a = na_reg; mul_b = nb_reg; end
            rfa_pkg::PROD_DA_NB: begin mul_a = da_reg; mul_b = nb_reg; end
            default:             begin mul_a = na_reg; mul_b = nb_reg; end
        endcase
        mul_p = mul_a * mul_b;
    end

    // unreduced pair for the current result
    always_comb
    begin
        case (pair_reg)
            rfa_pkg::PAIR_SUM:
            begin
                pair_n = prod_reg[rfa_pkg::PROD_NA_DB] + prod_reg[rfa_pkg::PROD_NB_DA];
                pair_d = prod_reg[rfa_pkg::PROD_DA_DB];
            end
            rfa_pkg::PAIR_DIFF:
            begin
                pair_n = prod_reg[rfa_pkg::PROD_NA_DB] - prod_reg[rfa_pkg::PROD_NB_DA];
                pair_d = prod_reg[rfa_pkg::PROD_DA_DB];
            end
            rfa_pkg::PAIR_PROD:
            begin
                pair_n = prod_reg[rfa_pkg::PROD_NA_NB];
                pair_d = prod_reg[rfa_pkg::PROD_DA_DB];
            end
            default:
            begin
                pair_n = prod_reg[rfa_pkg::PROD_NA_DB];
                pair_d = prod_reg[rfa_pkg::PROD_DA_NB];
            end
        endcase
    end

    // quotient pair is skipped when the second numerator is zero
    assign last_pair = (pair_reg == rfa_pkg::PAIR_QUOT)
                       || ((pair_reg == rfa_pkg::PAIR_PROD) && quot_inv_reg);
    assign res_idx   = {pair_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            zero_den_reg <= 1'b0;
            quot_inv_reg <= 1'b0;
            na_reg       <= '0;
            da_reg       <= '0;
            nb_reg       <= '0;
            db_reg       <= '0;
            mul_idx_reg  <= '0;
            pair_reg     <= rfa_pkg::PAIR_SUM;
            n_reg        <= '0;
            d_reg        <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            qn_reg       <= '0;
            div_req_reg  <= '0;
            for (int i = 0; i < rfa_pkg::NUM_PROD; i++)
                prod_reg[i] <= '0;
            for (int i = 0; i < rfa_pkg::NUM_RES; i++)
                res_reg[i] <= '0;
        end
        else
        begin
            done_reg          <= 1'b0;
            div_req_reg.start <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        na_reg       <= na_in;
                        da_reg       <= da_in;
                        nb_reg       <= nb_in;
                        db_reg       <= db_in;
                        zero_den_reg <= zero_den_in;
                        quot_inv_reg <= !zero_den_in && (nb_in == '0);
                        mul_idx_reg  <= '0;
                        pair_reg     <= rfa_pkg::PAIR_SUM;
                        for (int i = 0; i < rfa_pkg::NUM_RES; i++)
                            res_reg[i] <= '0;
                        if (zero_den_in)
                            done_reg <= 1'b1;
                        else
                            state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg[mul_idx_reg] <= rfa_pkg::RES_BITS'(mul_p);
                    if (mul_idx_reg == rfa_pkg::prod_idx_t'(rfa_pkg::NUM_PROD - 1))
                        state_reg <= S_LOAD;
                    else
                        mul_idx_reg <= mul_idx_reg + 1'b1;
                end
                S_LOAD:
                begin
                    n_reg     <= pair_n;
                    d_reg     <= pair_d;
                    x_reg     <= pair_n;
                    y_reg     <= pair_d;
                    state_reg <= S_GCD;
                end
                S_GCD:
                begin
                    if (y_reg == '0)
                    begin
                        if (x_reg == '0)
                        begin
                            // no gcd: both parts come out zero
                            res_reg[res_idx]        <= '0;
                            res_reg[res_idx + 1'b1] <= '0;
                            if (last_pair)
                            begin
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                pair_reg  <= pair_reg + 1'b1;
                                state_reg <= S_LOAD;
                            end
                        end
                        else
                        begin
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <= n_reg;
                            div_req_reg.divisor  <= x_reg;
                            state_reg            <= S_DIVN_WAIT;
                        end
                    end
                    else
                    begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= x_reg;
                        div_req_reg.divisor  <= y_reg;
                        state_reg            <= S_GCD_WAIT;
                    end
                end
                S_GCD_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        x_reg     <= y_reg;
                        y_reg     <= div_rsp.rem;
                        state_reg <= S_GCD;
                    end
                end
                S_DIVN_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        qn_reg               <= div_rsp.quot;
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= d_reg;
                        div_req_reg.divisor  <= x_reg;
                        state_reg            <= S_DIVD_WAIT;
                    end
                end
                S_DIVD_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        res_reg[res_idx]        <= qn_reg;
                        res_reg[res_idx + 1'b1] <= div_rsp.quot;
                        if (last_pair)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            pair_reg  <= pair_reg + 1'b1;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign sum_num        = res_reg[0];
    assign sum_den        = res_reg[1];
    assign diff_num       = res_reg[2];
    assign diff_den       = res_reg[3];
    assign prod_num       = res_reg[4];
    assign prod_den       = res_reg[5];
    assign quot_num       = res_reg[6];
    assign quot_den       = res_reg[7];
    assign zero_den_error = zero_den_reg;
    assign quot_invalid   = quot_inv_reg;

    `RFA_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy,
        "result strobe while sequencer busy")
    `RFA_ASSERT_NEXT(a_zero_den_fast, clk, rst_n,
        start && !busy && (den_a[rfa_pkg::OPERAND_BITS-1:0] == '0), done && zero_den_error,
        "zero denominator did not finish in one cycle")
    `RFA_ASSERT_NOW(a_zero_den_clear, clk, rst_n, done && zero_den_error,
        sum_num == '0 && sum_den == '0 && prod_den == '0 && quot_den == '0 && !quot_invalid,
        "zero denominator result not cleared")
    `RFA_ASSERT_NOW(a_quot_inv_clear, clk, rst_n, done && quot_invalid,
        quot_num == '0 && quot_den == '0 && !zero_den_error,
        "invalid quotient not zeroed")

endmodule
